[rtl/lru_et_pkg.sv]
// ----------------------------------------------------------------------------
// lru_et_pkg
// Types, sizes and helpers shared by the LRU entry table cells and top level.
// ----------------------------------------------------------------------------
package lru_et_pkg;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned OCC_W     = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W     = $clog2(DEPTH);

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] key_tag;
    logic [31:0] body_handle;
    logic [31:0] type_handle;
    logic [23:0] body_length;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_body;
    logic [31:0] found_type;
    logic [23:0] found_length;
    logic        evicted;
    logic [31:0] evicted_key;
  } res_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [31:0]          body;
    logic [31:0]          type_handle;
    logic [23:0]          len;
  } ent_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  function automatic logic [KEY_WIDTH-1:0] tag_to_key(logic [31:0] tag);
    logic [63:0] w;
    w = {32'b0, tag};
    return w[KEY_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] key_to_tag(logic [KEY_WIDTH-1:0] k);
    logic [63:0] w;
    w = '0;
    w[KEY_WIDTH-1:0] = k;
    return w[31:0];
  endfunction

endpackage

[rtl/lru_et_cell.sv]
// ----------------------------------------------------------------------------
// lru_et_cell
// One table slot: holds an entry, compares its key, shifts in its upper
// neighbor or loads the entry on its load input.
// ----------------------------------------------------------------------------
module lru_et_cell (
  input  logic                                  clk_i,
  input  lru_et_pkg::cell_ctl_t                 ctl_i,
  input  lru_et_pkg::ent_t                      nbr_i,
  input  lru_et_pkg::ent_t                      load_i,
  input  logic [lru_et_pkg::KEY_WIDTH-1:0]      key_i,
  output lru_et_pkg::ent_t                      ent_o,
  output logic                                  match_o
);
  import lru_et_pkg::*;

  ent_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.load) begin
      ent_d = load_i;
    end else if (ctl_i.shift) begin
      ent_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o   = ent_q;
  assign match_o = (ent_q.key == key_i);

endmodule

[rtl/lru_entry_table_top.sv]
// ----------------------------------------------------------------------------
// lru_entry_table_top
// LRU entry table built as a chain of slot cells, oldest at cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start_i; a transfer happens at a
//   rising edge with start_i high and busy_o low. busy_o is always low, so a
//   request may be issued every cycle.
//   Result channel: one result per request, on res_o with done_o high for
//   exactly one cycle, the cycle after the request transfer. The receiver
//   cannot stall; a result not taken in that cycle is gone.
//   Throughput: 1 request per cycle. All cells compare the key in parallel,
//   and the move-to-front or append shift through the cell chain completes
//   in the same edge as the transfer.
//   Lookup: on a hit the most recent matching entry is returned and moved to
//   the most-recent end. Insert: appends; a full table first drops cell 0 and
//   reports its key.
//   Reset: occupancy clears to zero, so the table is empty; no clearing pass
//   over the cells is needed.
// ----------------------------------------------------------------------------
module lru_entry_table_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lru_et_pkg::req_t  req_i,
  output logic              busy_o,
  output logic              done_o,
  output lru_et_pkg::res_t  res_o
);
  import lru_et_pkg::*;

  logic [OCC_W-1:0]     occ_q, occ_d;
  logic                 done_q;
  res_t                 res_q, res_d;

  ent_t                 ent    [DEPTH];
  ent_t                 nbr    [DEPTH];
  logic [DEPTH-1:0]     match;
  cell_ctl_t            ctl    [DEPTH];
  ent_t                 load_ent;
  ent_t                 new_ent;
  ent_t                 hit_ent;
  logic [KEY_WIDTH-1:0] key;
  logic [IDX_W-1:0]     hit_idx;
  logic                 found;
  logic                 full;
  logic                 accept;

  assign busy_o = 1'b0;
  assign accept = start_i;
  assign key    = tag_to_key(req_i.key_tag);
  assign full   = (occ_q == OCC_W'(DEPTH));

  assign new_ent.key         = key;
  assign new_ent.body        = req_i.body_handle;
  assign new_ent.type_handle = req_i.type_handle;
  assign new_ent.len         = req_i.body_length;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_last
      assign nbr[g] = '0;
    end else begin : g_mid
      assign nbr[g] = ent[g+1];
    end

    lru_et_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[g]),
      .nbr_i   (nbr[g]),
      .load_i  (load_ent),
      .key_i   (key),
      .ent_o   (ent[g]),
      .match_o (match[g])
    );
  end

  // highest matching valid slot is the most recently used copy
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i] && (OCC_W'(i) < occ_q)) begin
        found   = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit_ent  = ent[hit_idx];
  assign load_ent = (req_i.mode == MODE_LOOKUP) ? hit_ent : new_ent;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i] = '0;
      if (accept) begin
        if (req_i.mode == MODE_LOOKUP) begin
          if (found) begin
            ctl[i].shift = (IDX_W'(i) >= hit_idx) && (OCC_W'(i) < occ_q - 1'b1);
            ctl[i].load  = (OCC_W'(i) == occ_q - 1'b1);
          end
        end else if (full) begin
          ctl[i].shift = (i < DEPTH - 1);
          ctl[i].load  = (i == DEPTH - 1);
        end else begin
          ctl[i].load  = (OCC_W'(i) == occ_q);
        end
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    res_d = '0;
    if (req_i.mode == MODE_LOOKUP) begin
      if (found) begin
        res_d.hit          = 1'b1;
        res_d.found_body   = hit_ent.body;
        res_d.found_type   = hit_ent.type_handle;
        res_d.found_length = hit_ent.len;
      end
    end else if (full) begin
      res_d.evicted     = 1'b1;
      res_d.evicted_key = key_to_tag(ent[0].key);
    end else if (accept) begin
      occ_d = occ_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[sim/lru_et_checker.sv]
// ----------------------------------------------------------------------------
// lru_et_checker
// Watches the request and result channels of the LRU entry table. It keeps
// its own ordered copy of the table, works out the result of every request
// transfer, and compares each result transfer with the oldest result due.
// ----------------------------------------------------------------------------
module lru_et_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lru_et_pkg::req_t req_i,
  input  logic             busy_o,
  input  logic             done_o,
  input  lru_et_pkg::res_t res_o,
  output int               fail_cnt_o,
  output int               due_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lru_et_pkg::*;

  logic [KEY_WIDTH-1:0] tag_tbl   [DEPTH];
  logic [31:0]          body_tbl  [DEPTH];
  logic [31:0]          ctype_tbl [DEPTH];
  logic [23:0]          len_tbl   [DEPTH];
  int                   fill   = 0;
  int                   errors = 0;
  res_t                 res_due_q [$];

  // Applies one request to the table copy and returns the result it yields.
  function automatic res_t lru_access(req_t r);
    res_t                 o;
    logic [KEY_WIDTH-1:0] k;
    logic [KEY_WIDTH-1:0] hk;
    logic [31:0]          hb;
    logic [31:0]          ht;
    logic [23:0]          hl;
    int                   slot;
    o = '0;
    k = r.key_tag[KEY_WIDTH-1:0];
    if (r.mode == MODE_LOOKUP) begin
      slot = -1;
      for (int i = fill - 1; i >= 0; i--) begin
        if (tag_tbl[i] == k) begin
          slot = i;
          break;
        end
      end
      if (slot >= 0) begin
        hk = tag_tbl[slot];
        hb = body_tbl[slot];
        ht = ctype_tbl[slot];
        hl = len_tbl[slot];
        for (int i = slot; i < fill - 1; i++) begin
          tag_tbl[i]   = tag_tbl[i+1];
          body_tbl[i]  = body_tbl[i+1];
          ctype_tbl[i] = ctype_tbl[i+1];
          len_tbl[i]   = len_tbl[i+1];
        end
        tag_tbl[fill-1]   = hk;
        body_tbl[fill-1]  = hb;
        ctype_tbl[fill-1] = ht;
        len_tbl[fill-1]   = hl;
        o.hit          = 1'b1;
        o.found_body   = hb;
        o.found_type   = ht;
        o.found_length = hl;
      end
    end else begin
      if (fill >= DEPTH) begin
        o.evicted     = 1'b1;
        o.evicted_key = 32'(tag_tbl[0]);
        for (int i = 0; i < DEPTH - 1; i++) begin
          tag_tbl[i]   = tag_tbl[i+1];
          body_tbl[i]  = body_tbl[i+1];
          ctype_tbl[i] = ctype_tbl[i+1];
          len_tbl[i]   = len_tbl[i+1];
        end
        fill = DEPTH - 1;
      end
      tag_tbl[fill]   = k;
      body_tbl[fill]  = r.body_handle;
      ctype_tbl[fill] = r.type_handle;
      len_tbl[fill]   = r.body_length;
      fill++;
    end
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      fill = 0;
      res_due_q.delete();
      due_cnt_o <= 0;
    end else begin
      // result transfer first: it belongs to an earlier request
      if (done_o) begin
        if (res_due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, res_o);
          errors++;
        end else begin
          want = res_due_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(res_o.hit));
          check_field("found_body", want.found_body, res_o.found_body);
          check_field("found_type", want.found_type, res_o.found_type);
          check_field("found_length", 32'(want.found_length), 32'(res_o.found_length));
          check_field("evicted", 32'(want.evicted), 32'(res_o.evicted));
          check_field("evicted_key", want.evicted_key, res_o.evicted_key);
        end
      end
      if (start_i && !busy_o) res_due_q.push_back(lru_access(req_i));
      due_cnt_o <= res_due_q.size();
    end
    fail_cnt_o <= errors;
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives lookups and inserts into the LRU entry table: a directed sequence
// over empty, duplicate, hit, miss and full-table eviction cases, then random
// bursts drawn mostly from a small key pool so hits and evictions are common.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lru_et_pkg::*;

  localparam int NUM_RAND   = 1400;
  localparam int POOL_SIZE  = 12;
  localparam int STALL_LIMIT = 500;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;
  int   fail_cnt;
  int   due_cnt;
  int   quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lru_entry_table_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  lru_et_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .req_i     (req_i),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .res_o     (res_o),
    .fail_cnt_o(fail_cnt),
    .due_cnt_o (due_cnt)
  );

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t mk_req(logic m, logic [31:0] k, logic [31:0] b,
                                  logic [31:0] t, logic [23:0] l);
    req_t r;
    r.mode        = m;
    r.key_tag     = k;
    r.body_handle = b;
    r.type_handle = t;
    r.body_length = l;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_for(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    do @(posedge clk_i); while (due_cnt != 0);
  endtask

  initial begin
    logic [31:0] tag_pool [POOL_SIZE];
    req_t        r;
    int          sent;
    int          burst;
    bit          paused;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_req(mk_req(MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 24'h0));
    send_req(mk_req(MODE_INSERT, 32'h0, 32'h0, 32'h0, 24'h0));
    send_req(mk_req(MODE_INSERT, '1, '1, '1, '1));
    send_req(mk_req(MODE_LOOKUP, '1, '0, '0, '0));
    send_req(mk_req(MODE_LOOKUP, 32'h0, '1, '1, '1));
    send_req(mk_req(MODE_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 24'h0));
    send_req(mk_req(MODE_INSERT, 32'hA5A5_A5A5, 32'h1111_1111, 32'h2222_2222, 24'h000333));
    send_req(mk_req(MODE_INSERT, 32'hA5A5_A5A5, 32'h4444_4444, 32'h5555_5555, 24'h666666));
    send_req(mk_req(MODE_LOOKUP, 32'hA5A5_A5A5, 32'h0, 32'h0, 24'h0));
    for (int i = 0; i < 6; i++)
      send_req(mk_req(MODE_INSERT, 32'h5A5A_0000 + i, $urandom, $urandom, 24'($urandom)));
    send_req(mk_req(MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 24'h0));
    send_req(mk_req(MODE_LOOKUP, 32'hA5A5_A5A5, 32'h0, 32'h0, 24'h0));
    send_req(mk_req(MODE_LOOKUP, 32'h5A5A_0005, 32'h0, 32'h0, 24'h0));
    send_req(mk_req(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 24'h0));
    drain;

    // random bursts
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    sent   = 0;
    paused = 1'b0;
    while (sent < NUM_RAND) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 99) < 3)
          tag_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        r.mode        = ($urandom_range(0, 99) < 45) ? MODE_INSERT : MODE_LOOKUP;
        r.key_tag     = ($urandom_range(0, 99) < 82) ?
                        tag_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
        r.body_handle = $urandom;
        r.type_handle = $urandom;
        r.body_length = ($urandom_range(0, 9) == 0) ? '1 : 24'($urandom);
        send_req(r);
        sent++;
      end
      if (!paused && sent >= NUM_RAND / 2) begin
        drain;
        paused = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 6));
      end
    end

    drain;
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lru_et_pkg.sv
rtl/lru_et_cell.sv
rtl/lru_entry_table_top.sv
sim/lru_et_checker.sv
sim/testbench.sv
